// ===== src/comb_filter_reverb_top_macros.svh =====
// ----------------------------------------------------------------------------
// Comb reverb assertion macros
// Shorthand for clocked concurrent checks on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMB_FILTER_REVERB_TOP_MACROS_SVH
`define COMB_FILTER_REVERB_TOP_MACROS_SVH

// same-cycle implication
`define CFR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("comb reverb check failed");

// next-cycle implication
`define CFR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("comb reverb check failed");

`endif

// ===== src/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Comb reverb package
// Shared constants: delay length table, comb gains, register indexes.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int COMB_COUNT      = 4;
   localparam int COMB_IDX_WIDTH  = 2;
   localparam int TABLE_LEN_WIDTH = 14;
   localparam int TAP_WIDTH       = 3;
   localparam int DIVISOR_WIDTH   = 4;
   localparam int GAIN_WIDTH      = 17;
   localparam int OUT_GAIN_WIDTH  = 19;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DELAY_PRESET,
      CSR_CHANNEL_SET,
      CSR_SMOOTHING_TAPS
   } csr_index_type;

   localparam logic [TAP_WIDTH-1:0] TAPS_RESET = 3'd4;

   // [channel set][preset][comb]
   localparam logic [TABLE_LEN_WIDTH-1:0] LINE_LEN [2][4][COMB_COUNT] = '{
      '{ '{14'd2063, 14'd1847, 14'd1523, 14'd1277},
         '{14'd3089, 14'd2927, 14'd2801, 14'd2111},
         '{14'd5479, 14'd5077, 14'd4987, 14'd4057},
         '{14'd9929, 14'd7411, 14'd4951, 14'd1063} },
      '{ '{14'd2053, 14'd1867, 14'd1531, 14'd1259},
         '{14'd3109, 14'd2939, 14'd2803, 14'd2113},
         '{14'd5477, 14'd5059, 14'd4993, 14'd4051},
         '{14'd9949, 14'd7393, 14'd4957, 14'd1097} }
   };

   // feedback gain magnitudes, Q16, applied negated
   localparam logic [GAIN_WIDTH-1:0] GAIN_Q16 [COMB_COUNT] = '{
      17'd57233, 17'd53890, 17'd55791, 17'd55725
   };

   // ~0.15 in Q20
   localparam logic [OUT_GAIN_WIDTH-1:0] OUT_GAIN = 19'd157286;

endpackage

// ===== src/cfr_div.sv =====
// ----------------------------------------------------------------------------
// Comb reverb tap-average divider
// Unsigned divide by a small divisor (1..8), eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module cfr_div #(
   parameter int WIDTH = 27
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [WIDTH-1:0]                    dividend,
   input  logic [cfr_pkg::DIVISOR_WIDTH-1:0]   divisor,
   output logic                                done,
   output logic [WIDTH-1:0]                    quotient
);

   localparam int DIGIT = 8;
   localparam int NCH   = (WIDTH + DIGIT - 1) / DIGIT;
   localparam int PADW  = NCH * DIGIT;
   localparam int CNTW  = $clog2(NCH + 1);
   localparam int DVW   = cfr_pkg::DIVISOR_WIDTH;

   logic [PADW-1:0]  num_ff, num_in;
   logic [PADW-1:0]  quo_ff, quo_in;
   logic [DVW-1:0]   rem_ff, rem_in;
   logic [DVW-1:0]   div_ff, div_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DVW:0]     trial;
   logic [DVW-1:0]   rem_step;
   logic [DIGIT-1:0] q_digit;

   // one digit of restoring division; remainder stays below the divisor
   always_comb begin
      rem_step = rem_ff;
      q_digit  = '0;
      trial    = '0;
      for (int j = 0; j < DIGIT; j++) begin
         trial = {rem_step, num_ff[PADW-1-j]};
         if (trial >= {1'b0, div_ff}) begin
            trial              = trial - {1'b0, div_ff};
            q_digit[DIGIT-1-j] = 1'b1;
         end
         rem_step = trial[DVW-1:0];
      end
   end

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = PADW'(dividend);
         quo_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNTW'(NCH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << DIGIT;
         quo_in = {quo_ff[PADW-DIGIT-1:0], q_digit};
         rem_in = rem_step;
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[WIDTH-1:0];

endmodule

// ===== src/comb_filter_reverb_top.sv =====
// ----------------------------------------------------------------------------
// Comb reverb top level
// Four parallel comb delay lines with averaged taps; one dry word in, one
// reverberated word out, both on valid/ready channels (req_, rsp_).
// Configuration (delay preset, channel set, smoothing taps) is written on the
// csr_ port, one register per index; the user must do so only while the block
// is idle, which the block itself does not enforce. After reset a clearing
// pass writes zero to all 4*DELAY_DEPTH delay entries, one per cycle, and
// req_ready stays low until that pass ends. Each word then runs the four combs
// one after another through the single delay memory: per comb smoothing_taps+1
// tap reads, a tap-average divide, a multiply and a write back. When a line
// is shortened, its position is first realigned before its taps are read.
// The result sits in an output register; a new word is accepted while it
// waits, and a stalled receiver holds only the final hand-off of the next one.
// ----------------------------------------------------------------------------
`include "comb_filter_reverb_top_macros.svh"

module comb_filter_reverb_top #(
   parameter int DELAY_DEPTH  = 16384,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_sample_out,
   input  logic                                   csr_we,
   input  logic [cfr_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [cfr_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int NC        = cfr_pkg::COMB_COUNT;
   localparam int CIW       = cfr_pkg::COMB_IDX_WIDTH;
   localparam int TW        = cfr_pkg::TAP_WIDTH;
   localparam int DVW       = cfr_pkg::DIVISOR_WIDTH;
   localparam int SW        = SAMPLE_WIDTH;
   localparam int PW        = $clog2(DELAY_DEPTH);
   localparam int LW        = $clog2(DELAY_DEPTH + 1);
   localparam int LW1       = LW + 1;
   localparam int MEM_DEPTH = NC * DELAY_DEPTH;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int ACCW      = SW + 3;
   localparam int CW        = SW + 1;
   localparam int YW        = SW + 5;
   localparam int PRODW     = CW + cfr_pkg::GAIN_WIDTH;
   localparam int OUTPW     = YW + cfr_pkg::OUT_GAIN_WIDTH;
   localparam int XW        = OUTPW + 1;

   localparam logic [AW-1:0]  CLEAR_LAST = AW'(MEM_DEPTH - 1);
   localparam logic [LW-1:0]  DEPTH_LEN  = LW'(DELAY_DEPTH);
   localparam logic [CIW-1:0] LAST_COMB  = CIW'(NC - 1);
   localparam logic [AW-1:0]  BASE [NC]  = '{
      AW'(0), AW'(DELAY_DEPTH), AW'(2 * DELAY_DEPTH), AW'(3 * DELAY_DEPTH)
   };
   localparam logic signed [XW-1:0] ROUND16 = {{(XW-16){1'b0}}, 1'b1, 15'd0};
   localparam logic signed [XW-1:0] ROUND20 = {{(XW-20){1'b0}}, 1'b1, 19'd0};
   localparam logic signed [XW-1:0] SAT_HI  = {{(XW-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [XW-1:0] SAT_LO  = {{(XW-SW+1){1'b1}}, {(SW-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_NORM,
      ST_READ,
      ST_SETTLE,
      ST_DSTART,
      ST_DWAIT,
      ST_MUL,
      ST_WRITE,
      ST_FINAL,
      ST_OUT
   } state_type;

   function automatic logic signed [SW-1:0] sat_sample(input logic signed [XW-1:0] x);
      logic signed [SW-1:0] r;
      if (x > SAT_HI) begin
         r = SAT_HI[SW-1:0];
      end else if (x < SAT_LO) begin
         r = SAT_LO[SW-1:0];
      end else begin
         r = x[SW-1:0];
      end
      return r;
   endfunction

   state_type                state_ff, state_in;
   logic [AW-1:0]            clear_addr_ff, clear_addr_in;
   logic [1:0]               preset_ff, preset_in;
   logic                     chan_ff, chan_in;
   logic [TW-1:0]            taps_ff, taps_in;
   logic [PW-1:0]            pos_ff [NC];
   logic [PW-1:0]            pos_in [NC];
   logic [CIW-1:0]           comb_ff, comb_in;
   logic [PW-1:0]            tap_addr_ff, tap_addr_in;
   logic [TW-1:0]            tap_cnt_ff, tap_cnt_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic signed [ACCW-1:0]   acc_ff, acc_in;
   logic signed [SW-1:0]     a_ff, a_in;
   logic signed [CW-1:0]     c_ff, c_in;
   logic signed [ACCW-1:0]   sum_ff, sum_in;
   logic signed [PRODW-1:0]  prod_ff, prod_in;
   logic signed [OUTPW-1:0]  oprod_ff, oprod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]     rsp_data_ff, rsp_data_in;

   logic signed [SW-1:0]     mem [MEM_DEPTH];
   logic                     mem_we, mem_re;
   logic [AW-1:0]            mem_waddr, mem_raddr;
   logic signed [SW-1:0]     mem_wdata;
   logic signed [SW-1:0]     rd_data_ff;

   logic [cfr_pkg::TABLE_LEN_WIDTH-1:0] len_tab;
   logic [LW-1:0]            len_cur;
   logic [PW-1:0]            pos_cur;
   logic [AW-1:0]            base_cur;
   logic [LW1-1:0]           tap_sum;
   logic [PW-1:0]            tap_next;
   logic [LW-1:0]            pos_inc;
   logic [PW-1:0]            pos_wrap;
   logic signed [ACCW-1:0]   k_val;
   logic signed [ACCW-1:0]   c_full;
   logic signed [YW-1:0]     y_pre;
   logic signed [XW-1:0]     t16, t20;
   logic signed [SW-1:0]     w_val, y_val;

   logic                     div_start, div_done;
   logic [ACCW-1:0]          div_mag, div_q;
   logic [DVW-1:0]           div_divisor;

   cfr_div #(.WIDTH(ACCW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_mag),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      len_tab  = cfr_pkg::LINE_LEN[chan_ff][preset_ff][comb_ff];
      len_cur  = (LW'(len_tab) > DEPTH_LEN) ? DEPTH_LEN : LW'(len_tab);
      pos_cur  = pos_ff[comb_ff];
      base_cur = BASE[comb_ff];
      tap_sum  = LW1'(tap_addr_ff) + LW1'(2);
      tap_next = (tap_sum >= LW1'(len_cur)) ? PW'(tap_sum - LW1'(len_cur)) : PW'(tap_sum);
      pos_inc  = LW'(pos_cur) + LW'(1);
      pos_wrap = (pos_inc == len_cur) ? '0 : PW'(pos_inc);

      div_mag     = acc_ff[ACCW-1] ? ACCW'(-acc_ff) : ACCW'(acc_ff);
      div_divisor = DVW'(taps_ff) + DVW'(1);
      k_val       = acc_ff[ACCW-1] ? -$signed(div_q) : $signed(div_q);
      c_full      = ACCW'(a_ff) + k_val;

      t16   = ROUND16 - XW'(prod_ff);
      w_val = sat_sample(t16 >>> 16);
      y_pre = YW'(a_ff) + (YW'(sum_ff) <<< 1);
      t20   = XW'(oprod_ff) + ROUND20;
      y_val = sat_sample(t20 >>> 20);
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      preset_in     = preset_ff;
      chan_in       = chan_ff;
      taps_in       = taps_ff;
      pos_in        = pos_ff;
      comb_in       = comb_ff;
      tap_addr_in   = tap_addr_ff;
      tap_cnt_in    = tap_cnt_ff;
      rd_pend_in    = 1'b0;
      acc_in        = acc_ff;
      a_in          = a_ff;
      c_in          = c_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      oprod_in      = oprod_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = base_cur + AW'(pos_cur);
      mem_wdata     = w_val;
      mem_raddr     = base_cur + AW'(tap_addr_ff);
      div_start     = 1'b0;

      if (rd_pend_ff) begin
         acc_in = acc_ff + ACCW'(rd_data_ff);
      end

      if (csr_we) begin
         case (csr_index)
            cfr_pkg::CSR_DELAY_PRESET:   preset_in = csr_wdata[1:0];
            cfr_pkg::CSR_CHANNEL_SET:    chan_in   = csr_wdata[0];
            cfr_pkg::CSR_SMOOTHING_TAPS: taps_in   = csr_wdata[TW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clear_addr_ff;
            mem_wdata = '0;
            if (clear_addr_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clear_addr_in = clear_addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               a_in     = req_sample_in;
               sum_in   = '0;
               comb_in  = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // realign a position left beyond a shortened line
            if (LW'(pos_cur) >= len_cur) begin
               pos_in[comb_ff] = PW'(LW'(pos_cur) - len_cur);
            end else begin
               tap_addr_in = pos_cur;
               tap_cnt_in  = '0;
               acc_in      = '0;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            mem_re      = 1'b1;
            rd_pend_in  = 1'b1;
            tap_addr_in = tap_next;
            tap_cnt_in  = tap_cnt_ff + TW'(1);
            if (tap_cnt_ff == taps_ff) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               c_in     = CW'(c_full);
               sum_in   = sum_ff + c_full;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PRODW'(c_ff) * PRODW'($signed(cfr_pkg::GAIN_Q16[comb_ff]));
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_we          = 1'b1;
            pos_in[comb_ff] = pos_wrap;
            if (comb_ff == LAST_COMB) begin
               state_in = ST_FINAL;
            end else begin
               comb_in  = comb_ff + CIW'(1);
               state_in = ST_NORM;
            end
         end
         ST_FINAL: begin
            oprod_in = OUTPW'(y_pre) * OUTPW'($signed(cfr_pkg::OUT_GAIN));
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = y_val;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         preset_ff     <= '0;
         chan_ff       <= 1'b0;
         taps_ff       <= cfr_pkg::TAPS_RESET;
         pos_ff        <= '{default: '0};
         comb_ff       <= '0;
         tap_cnt_ff    <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         preset_ff     <= preset_in;
         chan_ff       <= chan_in;
         taps_ff       <= taps_in;
         pos_ff        <= pos_in;
         comb_ff       <= comb_in;
         tap_cnt_ff    <= tap_cnt_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      tap_addr_ff <= tap_addr_in;
      acc_ff      <= acc_in;
      a_ff        <= a_in;
      c_ff        <= c_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      oprod_ff    <= oprod_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   `CFR_ASSERT_IMP(a_tap_in_line, state_ff == ST_READ, LW'(tap_addr_ff) < len_cur)
   `CFR_ASSERT_NXT(a_clear_ends, (state_ff == ST_CLEAR) && (clear_addr_ff == CLEAR_LAST), state_ff == ST_IDLE)
   `CFR_ASSERT_IMP(a_rd_pend, rd_pend_ff, (state_ff == ST_READ) || (state_ff == ST_SETTLE))
   `CFR_ASSERT_IMP(a_div_done, div_done, state_ff == ST_DWAIT)
   `CFR_ASSERT_IMP(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT)

endmodule
